/* sv/u8d_pkg.sv */
`timescale 1ns / 1ps
// Package for the UTF-8 stream decoder: byte class masks, result and state types.
// No dependencies; used by every module of the decoder.
package u8d_pkg;

  localparam int CpW  = 21;
  localparam int LenW = 3;

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContCode  = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Code = 8'hF0;
  localparam logic [7:0] Pay2Mask  = 8'h1F;
  localparam logic [7:0] Pay3Mask  = 8'h0F;
  localparam logic [7:0] Pay4Mask  = 8'h07;
  localparam logic [7:0] PayCMask  = 8'h3F;
  localparam logic [7:0] AsciiBit  = 8'h80;

  localparam logic [LenW-1:0] Len1 = 3'd1;
  localparam logic [LenW-1:0] Len2 = 3'd2;
  localparam logic [LenW-1:0] Len3 = 3'd3;
  localparam logic [LenW-1:0] Len4 = 3'd4;

  typedef struct packed {
    logic [LenW-1:0] seq_length;
    logic [CpW-1:0]  code_point;
  } result_t;

  typedef struct packed {
    logic [CpW-1:0]  acc;
    logic [1:0]      pending;
    logic [LenW-1:0] total;
  } seq_state_t;

endpackage

/* sv/u8d_core.sv */
`timescale 1ns / 1ps
// Decode stage: sequence state registers and per-byte decode logic.
// Depends on u8d_pkg for masks, the result type and the state type.
module u8d_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_fire,
  input  logic [7:0]      byte_in,
  input  logic            stream_end,
  output logic            res_valid,
  output u8d_pkg::result_t res
);

  u8d_pkg::seq_state_t st_r, st_nxt, lead;
  logic cont;

  always_comb begin
    cont      = (byte_in & u8d_pkg::ContMask) == u8d_pkg::ContCode;
    lead      = '0;
    res_valid = 1'b0;
    res       = '0;
    if ((byte_in & u8d_pkg::Lead2Mask) == u8d_pkg::Lead2Code) begin
      lead.acc     = u8d_pkg::CpW'(byte_in & u8d_pkg::Pay2Mask);
      lead.pending = 2'd1;
      lead.total   = u8d_pkg::Len2;
    end else if ((byte_in & u8d_pkg::Lead3Mask) == u8d_pkg::Lead3Code) begin
      lead.acc     = u8d_pkg::CpW'(byte_in & u8d_pkg::Pay3Mask);
      lead.pending = 2'd2;
      lead.total   = u8d_pkg::Len3;
    end else if ((byte_in & u8d_pkg::Lead4Mask) == u8d_pkg::Lead4Code) begin
      lead.acc     = u8d_pkg::CpW'(byte_in & u8d_pkg::Pay4Mask);
      lead.pending = 2'd3;
      lead.total   = u8d_pkg::Len4;
    end

    if (st_r.pending != 2'd0 && cont) begin
      // shift in six payload bits
      st_nxt.acc     = {st_r.acc[u8d_pkg::CpW-7:0], byte_in[5:0] & u8d_pkg::PayCMask[5:0]};
      st_nxt.pending = st_r.pending - 2'd1;
      st_nxt.total   = st_r.total;
      if (st_r.pending == 2'd1) begin
        res_valid      = 1'b1;
        res.code_point = st_nxt.acc;
        res.seq_length = st_r.total;
        st_nxt         = '0;
      end
    end else if ((byte_in & u8d_pkg::AsciiBit) == 8'h00) begin
      res_valid      = 1'b1;
      res.code_point = u8d_pkg::CpW'(byte_in);
      res.seq_length = u8d_pkg::Len1;
      st_nxt         = '0;
    end else begin
      // abandon any open sequence; drop stray continuation or invalid lead
      st_nxt = lead;
    end

    if (stream_end) st_nxt = '0;
    if (!byte_fire) begin
      st_nxt    = st_r;
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

/* sv/u8d_out_reg.sv */
`timescale 1ns / 1ps
// Result register with one skid entry; keeps the input side open while a single result waits.
// Depends on u8d_pkg for the result type.
module u8d_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8d_pkg::result_t push_data,
  output logic             can_accept,
  output logic             out_valid,
  input  logic             out_ready,
  output u8d_pkg::result_t out_data
);

  logic             out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  u8d_pkg::result_t out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        // advance the skid entry; no push is possible while it is full
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = push;
        out_d_nxt = push_data;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign can_accept = !skid_v_r;
  assign out_valid  = out_v_r;
  assign out_data   = out_d_r;

endmodule

/* sv/utf8_stream_decoder.sv */
`timescale 1ns / 1ps
// UTF-8 stream decoder: one byte per transfer in, one code point per completed sequence out.
// A result is registered in u8d_out_reg (output register, or skid entry on a stall) before it reaches out_*.
// Throughput: one byte per cycle while in_tready is high; the skid entry in u8d_out_reg keeps in_tready high
// while a single result waits on a stalled output and drops it only while both result slots are full.
// Reset: synchronous active-low rst_n clears the open sequence and both result slots.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,   // stream_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [20:0] code_point, [23:21] seq_length
);

  logic             byte_fire, res_valid;
  u8d_pkg::result_t res, out_res;

  assign byte_fire = in_tvalid && in_tready;

  u8d_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_fire  (byte_fire),
    .byte_in    (in_tdata),
    .stream_end (in_tlast),
    .res_valid  (res_valid),
    .res        (res)
  );

  u8d_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = out_res;

endmodule

/* sv/u8d_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for utf8_stream_decoder, attached by the bind below.
// Depends only on the top-level ports.
module u8d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:21] == 3'd1 || out_tdata[23:21] == 3'd2 ||
                    out_tdata[23:21] == 3'd3 || out_tdata[23:21] == 3'd4))
    else $error("seq_length out of range");

  a_ascii_cp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[23:21] == 3'd1 |-> out_tdata[20:7] == '0)
    else $error("single-byte result above 7 bits");

  a_two_cp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[23:21] == 3'd2 |-> out_tdata[20:11] == '0)
    else $error("two-byte result above 11 bits");

  a_ascii_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tdata[7] |=> out_tvalid)
    else $error("ascii transfer gave no result");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* test/utf8_decode_checker.sv */
`timescale 1ns / 1ps
// Checker for the UTF-8 stream decoder: watches both stream channels, predicts code points
// from the accepted bytes and compares every output transfer. Depends on u8d_pkg.
module utf8_decode_checker
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,   // stream_end
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [20:0] code_point, [23:21] seq_length
  output int          error_count,
  output int          pending_count
);

  // Decoder state as the byte stream has left it
  logic [CpW-1:0]  acc;
  logic [1:0]      bytes_left;
  logic [LenW-1:0] seq_total;

  result_t code_points_due[$];

  initial begin
    error_count   = 0;
    pending_count = 0;
    acc           = '0;
    bytes_left    = '0;
    seq_total     = '0;
  end

  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output result_t res);
    bit emit;
    emit = 1'b0;
    res  = '0;
    if (bytes_left != 2'd0 && (b & ContMask) == ContCode) begin
      acc        = (acc << 6) | CpW'(b & PayCMask);
      bytes_left = bytes_left - 2'd1;
      if (bytes_left == 2'd0) begin
        res.code_point = acc;
        res.seq_length = seq_total;
        emit           = 1'b1;
        {acc, bytes_left, seq_total} = '0;
      end
    end else begin
      // Abandon any open sequence and treat the byte as a new lead
      {acc, bytes_left, seq_total} = '0;
      if ((b & AsciiBit) == 8'h00) begin
        res.code_point = CpW'(b);
        res.seq_length = Len1;
        emit           = 1'b1;
      end else if ((b & Lead2Mask) == Lead2Code) begin
        acc        = CpW'(b & Pay2Mask);
        bytes_left = 2'd1;
        seq_total  = Len2;
      end else if ((b & Lead3Mask) == Lead3Code) begin
        acc        = CpW'(b & Pay3Mask);
        bytes_left = 2'd2;
        seq_total  = Len3;
      end else if ((b & Lead4Mask) == Lead4Code) begin
        acc        = CpW'(b & Pay4Mask);
        bytes_left = 2'd3;
        seq_total  = Len4;
      end
    end
    if (last) {acc, bytes_left, seq_total} = '0;
    return emit;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t res;
    if (!rst_n) begin
      {acc, bytes_left, seq_total} = '0;
      code_points_due.delete();
    end else begin
      // Check the output first: a result never comes from the byte of the same edge
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        if (code_points_due.size() == 0) begin
          if (error_count < 10)
            $display("%0t: unexpected result cp=%h len=%0d", $realtime,
                     got.code_point, got.seq_length);
          error_count++;
        end else begin
          want = code_points_due.pop_front();
          if (got.code_point !== want.code_point || got.seq_length !== want.seq_length) begin
            if (error_count < 10)
              $display("%0t: mismatch expected cp=%h len=%0d, got cp=%h len=%0d",
                       $realtime, want.code_point, want.seq_length,
                       got.code_point, got.seq_length);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (decode_byte(in_tdata, in_tlast, res)) code_points_due = {code_points_due, res};
      end
    end
    pending_count = code_points_due.size();
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Top of the UTF-8 stream decoder test: drives byte transfers and output backpressure,
// and gives the verdict. Depends on u8d_pkg, utf8_stream_decoder and utf8_decode_checker.
module testbench;
  import u8d_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandomItems = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  int  error_count;
  int  pending_count;
  int  cycle_count = 0;
  bit  send_idles = 1'b1;
  bit  recv_stalls = 1'b1;
  int  items_sent = 0;

  always #5 clk = ~clk;

  utf8_stream_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  utf8_decode_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Hold each byte until its transfer completes; idle only when the draw says so
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = send_idles ? $urandom_range(0, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [7:0] lead_byte(input int len, input logic [7:0] r);
    case (len)
      1:       return {1'b0, r[6:0]};
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      default: return {5'b11110, r[2:0]};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte(input logic [7:0] r);
    return {2'b10, r[5:0]};
  endfunction

  function automatic logic rand_last();
    return ($urandom_range(0, 24) == 0);
  endfunction

  // Output backpressure: one stall draw per result
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 199) == 0) recv_stalls = ~recv_stalls;
      stall = recv_stalls ? $urandom_range(0, 17) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    int kind;
    int len;
    int cut;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ASCII extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    // Smallest and largest payload of every length
    send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // Stray continuations and invalid leads
    send_byte(8'h80, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hF8, 1'b0); send_byte(8'hFF, 1'b0);
    // Sequence cut by ASCII, by a new lead, and by an invalid lead
    send_byte(8'hC3, 1'b0); send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h80, 1'b0);
    // Stream end inside a sequence, then on the completing byte
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1); send_byte(8'hAC, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b1);
    send_byte(8'h7F, 1'b1);

    // Random: mostly well-formed sequences, some cut short, some noise
    while (items_sent < RandomItems) begin
      if ($urandom_range(0, 149) == 0) send_idles = ~send_idles;
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      if (kind < 70) begin
        send_byte(lead_byte(len, 8'($urandom)), rand_last());
        repeat (len - 1) send_byte(cont_byte(8'($urandom)), rand_last());
        items_sent += len;
      end else if (kind < 85) begin
        cut = (len > 1) ? $urandom_range(0, len - 2) : 0;
        send_byte(lead_byte(len, 8'($urandom)), rand_last());
        repeat (cut) send_byte(cont_byte(8'($urandom)), rand_last());
        items_sent += cut + 1;
      end else begin
        send_byte(8'($urandom), rand_last());
        items_sent += 1;
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
